// ----- rtl/core/scbf_pkg.sv -----
// Shared types and constants of the saturating counting Bloom filter.
`timescale 1ns / 1ps

package scbf_pkg;

    localparam int ABUND_W    = 8;
    localparam int COUNT_W    = 8;
    localparam int TOTAL_W    = 17;
    localparam int CFG_ADDR_W = 2;
    localparam int RES_DEPTH  = 4;
    localparam int RES_LVL_W  = $clog2(RES_DEPTH + 1);

    localparam logic OP_COUNT = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_MIN_ABUND = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_ABUND = 2'd1;

    typedef struct packed {
        logic               clear_start;
        logic [ABUND_W-1:0] min_abundance;
        logic [ABUND_W-1:0] max_abundance;
    } ctrl_t;

    typedef struct packed {
        logic               present;
        logic [COUNT_W-1:0] count_value;
        logic [TOTAL_W-1:0] below_min_entries;
        logic [TOTAL_W-1:0] at_max_entries;
    } result_t;

endpackage

// ----- rtl/core/saturating_counting_bloom_filter.sv -----
// Top level of the saturating single-hash counting Bloom filter.
//
// Items enter through a queue interface: an item (operation, key_hash) is taken when
// push is high and full is low. Results leave through a queue interface: the oldest
// result is on the result ports while empty is low and is taken when pop is high.
// Every item yields exactly one result, in order.
// An item passes the input queue, a pipelined counter read-modify-write (one registered
// memory read, an update step, the last update forwarded) and the result queue. One
// item per cycle is sustained while no clearing pass runs and the result queue has
// room. After reset and after every threshold register write, a clearing pass zeroes
// all 2^INDEX_BITS counter entries, one entry per cycle; full stays high meanwhile.
// Configuration writes are always accepted (cfg_ready is tied high) and, at the
// threshold registers, also clear the totals; they are meant to be issued only while
// no item is in flight. When the receiver stops popping, the four-entry result queue
// fills, processing stops, and the four-entry input queue then raises full.
`timescale 1ns / 1ps

module saturating_counting_bloom_filter #(
    parameter int INDEX_BITS   = 16,
    parameter int COUNTER_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              operation,
    input  logic [63:0]                       key_hash,
    output logic                              empty,
    input  logic                              pop,
    output logic                              present,
    output logic [scbf_pkg::COUNT_W-1:0]      count_value,
    output logic [scbf_pkg::TOTAL_W-1:0]      below_min_entries,
    output logic [scbf_pkg::TOTAL_W-1:0]      at_max_entries,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [scbf_pkg::CFG_ADDR_W-1:0]   cfg_index,
    input  logic [scbf_pkg::ABUND_W-1:0]      cfg_data
);

    localparam int ITEM_W   = INDEX_BITS + 1;
    localparam int RES_W    = $bits(scbf_pkg::result_t);
    localparam int IN_DEPTH = 4;
    localparam int IN_LVL_W = $clog2(IN_DEPTH + 1);

    logic [scbf_pkg::ABUND_W-1:0]   min_abund_reg;
    logic [scbf_pkg::ABUND_W-1:0]   max_abund_reg;
    logic                           cfg_hit;
    scbf_pkg::ctrl_t                ctrl;
    logic                           in_full;
    logic                           in_empty;
    logic                           in_pop;
    logic [ITEM_W-1:0]              in_item;
    logic [IN_LVL_W-1:0]            in_level;
    logic                           res_push;
    scbf_pkg::result_t              res_data;
    scbf_pkg::result_t              res_head;
    logic [RES_W-1:0]               res_rdata;
    logic [scbf_pkg::RES_LVL_W-1:0] res_level;
    logic                           res_full;
    logic                           clearing;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        unique case (cfg_index)
            scbf_pkg::REG_MIN_ABUND: cfg_hit = cfg_valid;
            scbf_pkg::REG_MAX_ABUND: cfg_hit = cfg_valid;
            default:                 cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_abund_reg <= 8'd1;
            max_abund_reg <= 8'd255;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == scbf_pkg::REG_MIN_ABUND)
            begin
                min_abund_reg <= cfg_data;
            end
            if (cfg_index == scbf_pkg::REG_MAX_ABUND)
            begin
                max_abund_reg <= cfg_data;
            end
        end
    end

    assign ctrl.clear_start   = cfg_hit;
    assign ctrl.min_abundance = min_abund_reg;
    assign ctrl.max_abundance = max_abund_reg;

    assign full = in_full || clearing;

    scbf_fifo #(
        .WIDTH(ITEM_W),
        .DEPTH(IN_DEPTH)
    ) u_in_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && !clearing),
        .full  (in_full),
        .wdata ({operation, key_hash[INDEX_BITS-1:0]}),
        .pop   (in_pop),
        .empty (in_empty),
        .rdata (in_item),
        .level (in_level)
    );

    scbf_back #(
        .INDEX_BITS  (INDEX_BITS),
        .COUNTER_BITS(COUNTER_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .in_empty (in_empty),
        .in_item  (in_item),
        .in_pop   (in_pop),
        .res_level(res_level),
        .res_push (res_push),
        .res_data (res_data),
        .clearing (clearing)
    );

    scbf_fifo #(
        .WIDTH(RES_W),
        .DEPTH(scbf_pkg::RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata (res_data),
        .pop   (pop),
        .empty (empty),
        .rdata (res_rdata),
        .level (res_level)
    );

    assign res_head          = scbf_pkg::result_t'(res_rdata);
    assign present           = res_head.present;
    assign count_value       = res_head.count_value;
    assign below_min_entries = res_head.below_min_entries;
    assign at_max_entries    = res_head.at_max_entries;

`ifndef SYNTHESIS
    a_no_push_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("Result pushed into a full result queue.");

    a_full_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> full)
        else $error("Input open during the clearing pass.");

    a_clear_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> clearing)
        else $error("Configuration write did not start a clearing pass.");

    a_in_full_level: assert property (@(posedge clk) disable iff (!rst_n)
        in_full |-> (in_level == IN_LVL_W'(IN_DEPTH)))
        else $error("Input queue reports full below its depth.");
`endif

endmodule

// ----- rtl/core/scbf_fifo.sv -----
// Small synchronous queue used for the item and result channels.
`timescale 1ns / 1ps

module scbf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [WIDTH-1:0]             wdata,
    input  logic                         pop,
    output logic                         empty,
    output logic [WIDTH-1:0]             rdata,
    output logic [$clog2(DEPTH+1)-1:0]   level
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (level_reg == LVL_W'(DEPTH));
    assign empty   = (level_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];
    assign level   = level_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/core/scbf_back.sv -----
// Counter store with read-modify-write pipeline, running totals and clearing pass.
`timescale 1ns / 1ps

module scbf_back #(
    parameter int INDEX_BITS   = 16,
    parameter int COUNTER_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  scbf_pkg::ctrl_t                  ctrl,
    input  logic                             in_empty,
    input  logic [INDEX_BITS:0]              in_item,
    output logic                             in_pop,
    input  logic [scbf_pkg::RES_LVL_W-1:0]   res_level,
    output logic                             res_push,
    output scbf_pkg::result_t                res_data,
    output logic                             clearing
);

    localparam int DEPTH = 1 << INDEX_BITS;
    localparam int CMP_W = (COUNTER_BITS > scbf_pkg::ABUND_W) ? COUNTER_BITS
                                                              : scbf_pkg::ABUND_W;
    localparam int TW    = scbf_pkg::TOTAL_W;
    localparam int LW    = scbf_pkg::RES_LVL_W;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

    logic [COUNTER_BITS-1:0] counter_mem [DEPTH];

    logic                    clearing_reg;
    logic                    clearing_next;
    logic [INDEX_BITS-1:0]   clear_idx_reg;
    logic [INDEX_BITS-1:0]   clear_idx_next;
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic                    s1_op_reg;
    logic [INDEX_BITS-1:0]   s1_idx_reg;
    logic [COUNTER_BITS-1:0] rd_data_reg;
    logic                    fwd_valid_reg;
    logic                    fwd_valid_next;
    logic [INDEX_BITS-1:0]   fwd_idx_reg;
    logic [COUNTER_BITS-1:0] fwd_val_reg;
    logic [TW-1:0]           below_total_reg;
    logic [TW-1:0]           below_total_next;
    logic [TW-1:0]           at_total_reg;
    logic [TW-1:0]           at_total_next;

    logic [INDEX_BITS-1:0]   head_idx;
    logic                    issue;
    logic [COUNTER_BITS-1:0] cur_cnt;
    logic [COUNTER_BITS-1:0] new_cnt;
    logic [CMP_W-1:0]        cur_ext;
    logic [CMP_W-1:0]        new_ext;
    logic [CMP_W-1:0]        min_ext;
    logic [CMP_W-1:0]        max_ext;
    logic                    do_inc;
    logic                    below_old;
    logic                    below_new;
    logic                    at_old;
    logic                    at_new;
    logic                    mem_we;
    logic [INDEX_BITS-1:0]   mem_waddr;
    logic [COUNTER_BITS-1:0] mem_wdata;

    assign head_idx = in_item[INDEX_BITS-1:0];
    assign issue    = !in_empty && !clearing_reg && !ctrl.clear_start
                      && ((LW + 1)'(res_level) + (LW + 1)'(s1_valid_reg)
                          < (LW + 1)'(scbf_pkg::RES_DEPTH));
    assign in_pop   = issue;
    assign clearing = clearing_reg;

    assign min_ext = CMP_W'(ctrl.min_abundance);
    assign max_ext = CMP_W'(ctrl.max_abundance);

    always_comb
    begin
        cur_cnt = (fwd_valid_reg && (fwd_idx_reg == s1_idx_reg)) ? fwd_val_reg : rd_data_reg;
        cur_ext = CMP_W'(cur_cnt);
        do_inc  = s1_valid_reg && (s1_op_reg == scbf_pkg::OP_COUNT)
                  && (cur_ext < max_ext) && (cur_cnt != CNT_MAX);
        new_cnt = do_inc ? cur_cnt + 1'b1 : cur_cnt;
        new_ext = CMP_W'(new_cnt);

        below_old = (cur_ext != '0) && (cur_ext < min_ext);
        at_old    = (cur_ext != '0) && (cur_ext == max_ext);
        below_new = (new_ext != '0) && (new_ext < min_ext);
        at_new    = (new_ext != '0) && (new_ext == max_ext);

        below_total_next = below_total_reg;
        at_total_next    = at_total_reg;
        if (do_inc)
        begin
            below_total_next = below_total_reg - TW'(below_old) + TW'(below_new);
            at_total_next    = at_total_reg - TW'(at_old) + TW'(at_new);
        end

        res_push                   = s1_valid_reg;
        res_data.present           = (new_ext >= min_ext) && (new_ext < max_ext);
        res_data.count_value       = new_ext[scbf_pkg::COUNT_W-1:0];
        res_data.below_min_entries = below_total_next;
        res_data.at_max_entries    = at_total_next;
    end

    always_comb
    begin
        clearing_next  = clearing_reg;
        clear_idx_next = clear_idx_reg;
        s1_valid_next  = issue;
        fwd_valid_next = s1_valid_reg;
        if (ctrl.clear_start)
        begin
            clearing_next  = 1'b1;
            clear_idx_next = '0;
            s1_valid_next  = 1'b0;
            fwd_valid_next = 1'b0;
        end
        else if (clearing_reg)
        begin
            clear_idx_next = clear_idx_reg + 1'b1;
            if (clear_idx_reg == '1)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clear_idx_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = do_inc;
            mem_waddr = s1_idx_reg;
            mem_wdata = new_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg    <= 1'b1;
            clear_idx_reg   <= '0;
            s1_valid_reg    <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            below_total_reg <= '0;
            at_total_reg    <= '0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clear_idx_reg <= clear_idx_next;
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            if (ctrl.clear_start)
            begin
                below_total_reg <= '0;
                at_total_reg    <= '0;
            end
            else
            begin
                below_total_reg <= below_total_next;
                at_total_reg    <= at_total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg   <= in_item[INDEX_BITS];
        s1_idx_reg  <= head_idx;
        fwd_idx_reg <= s1_idx_reg;
        fwd_val_reg <= new_cnt;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            counter_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= counter_mem[head_idx];
    end

`ifndef SYNTHESIS
    a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s1_valid_reg)
        else $error("Item in the pipeline during the clearing pass.");

    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (res_level < LW'(scbf_pkg::RES_DEPTH)))
        else $error("Result queue has no room for a finishing item.");

    a_totals_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_valid_reg && !ctrl.clear_start) |=>
            ($stable(below_total_reg) && $stable(at_total_reg)))
        else $error("Running totals changed without an item.");

    a_clear_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (clearing_reg && !ctrl.clear_start) |=>
            (!clearing_reg || (clear_idx_reg == $past(clear_idx_reg) + 1'b1)))
        else $error("Clearing pass skipped an entry.");
`endif

endmodule

// ----- dv/scbf_checker.sv -----
// Checker for the saturating counting Bloom filter: it predicts every result and compares it.
`timescale 1ns / 1ps

module scbf_checker #(
    parameter int INDEX_BITS   = 16,
    parameter int COUNTER_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic                                full,
    input  logic                                operation,
    input  logic [63:0]                         key_hash,
    input  logic                                empty,
    input  logic                                pop,
    input  logic                                present,
    input  logic [scbf_pkg::COUNT_W-1:0]        count_value,
    input  logic [scbf_pkg::TOTAL_W-1:0]        below_min_entries,
    input  logic [scbf_pkg::TOTAL_W-1:0]        at_max_entries,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [scbf_pkg::CFG_ADDR_W-1:0]     cfg_index,
    input  logic [scbf_pkg::ABUND_W-1:0]        cfg_data,
    output int                                  mismatches,
    output int                                  pending
);
    import scbf_pkg::*;

    localparam int DEPTH       = 1 << INDEX_BITS;
    localparam int COUNTER_TOP = (1 << COUNTER_BITS) - 1;

    bit [COUNTER_BITS-1:0] tally [DEPTH];
    bit [TOTAL_W-1:0]      sparse_total;
    bit [TOTAL_W-1:0]      saturated_total;
    bit [ABUND_W-1:0]      min_level;
    bit [ABUND_W-1:0]      max_level;
    result_t               awaited_q [$];

    function automatic bit under_min(int c);
        return c > 0 && c < int'(min_level);
    endfunction

    function automatic bit at_ceiling(int c);
        return c > 0 && c == int'(max_level);
    endfunction

    task automatic wipe_tally();
        foreach (tally[i])
        begin
            tally[i] = '0;
        end
        sparse_total    = '0;
        saturated_total = '0;
    endtask

    function automatic result_t tally_item(logic op, logic [63:0] hash);
        int      slot;
        int      c;
        int      n;
        int      limit;
        result_t r;
        slot  = int'(hash[INDEX_BITS-1:0]);
        c     = int'(tally[slot]);
        limit = (int'(max_level) < COUNTER_TOP) ? int'(max_level) : COUNTER_TOP;
        if (op == OP_COUNT && c < limit)
        begin
            n = c + 1;
            if (under_min(c))
                sparse_total--;
            if (at_ceiling(c))
                saturated_total--;
            if (under_min(n))
                sparse_total++;
            if (at_ceiling(n))
                saturated_total++;
            tally[slot] = n[COUNTER_BITS-1:0];
            c = n;
        end
        r.present           = (c >= int'(min_level) && c < int'(max_level));
        r.count_value       = c[COUNT_W-1:0];
        r.below_min_entries = sparse_total;
        r.at_max_entries    = saturated_total;
        return r;
    endfunction

    task automatic record_expected(input result_t r);
        awaited_q.insert(awaited_q.size(), r);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_result();
        result_t want;
        if (awaited_q.size() == 0)
        begin
            report_mismatch("result with no item waiting", longint'(count_value), 0);
        end
        else
        begin
            want = awaited_q.pop_front();
            if (present !== want.present)
                report_mismatch("present", longint'(present), longint'(want.present));
            if (count_value !== want.count_value)
                report_mismatch("count_value", longint'(count_value),
                                longint'(want.count_value));
            if (below_min_entries !== want.below_min_entries)
                report_mismatch("below_min_entries", longint'(below_min_entries),
                                longint'(want.below_min_entries));
            if (at_max_entries !== want.at_max_entries)
                report_mismatch("at_max_entries", longint'(at_max_entries),
                                longint'(want.at_max_entries));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_tally();
            min_level  = 8'd1;
            max_level  = 8'd255;
            awaited_q.delete();
            pending    = 0;
            mismatches = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MIN_ABUND:
                    begin
                        min_level = cfg_data;
                        wipe_tally();
                    end
                    REG_MAX_ABUND:
                    begin
                        max_level = cfg_data;
                        wipe_tally();
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (pop && !empty)
                check_result();
            if (push && !full)
                record_expected(tally_item(operation, key_hash));
            pending = awaited_q.size();
        end
    end

endmodule

// ----- dv/saturating_counting_bloom_filter_tb.sv -----
// Testbench top for the saturating counting Bloom filter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module saturating_counting_bloom_filter_tb;
    import scbf_pkg::*;

    localparam int INDEX_BITS   = 16;
    localparam int COUNTER_BITS = 8;
    localparam int CYCLE_LIMIT  = 4000000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  push      = 1'b0;
    logic                  operation = 1'b0;
    logic [63:0]           key_hash  = '0;
    logic                  pop       = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_index = '0;
    logic [ABUND_W-1:0]    cfg_data  = '0;

    logic                  full;
    logic                  empty;
    logic                  present;
    logic [COUNT_W-1:0]    count_value;
    logic [TOTAL_W-1:0]    below_min_entries;
    logic [TOTAL_W-1:0]    at_max_entries;
    logic                  cfg_ready;

    int                    mismatches;
    int                    pending;
    int                    cycle_count = 0;
    int                    pop_stall   = 0;
    int                    pop_calm    = 0;
    int                    push_calm   = 0;

    saturating_counting_bloom_filter #(
        .INDEX_BITS   (INDEX_BITS),
        .COUNTER_BITS (COUNTER_BITS)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .operation         (operation),
        .key_hash          (key_hash),
        .empty             (empty),
        .pop               (pop),
        .present           (present),
        .count_value       (count_value),
        .below_min_entries (below_min_entries),
        .at_max_entries    (at_max_entries),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    scbf_checker #(
        .INDEX_BITS   (INDEX_BITS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .operation         (operation),
        .key_hash          (key_hash),
        .empty             (empty),
        .pop               (pop),
        .present           (present),
        .count_value       (count_value),
        .below_min_entries (below_min_entries),
        .at_max_entries    (at_max_entries),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .mismatches        (mismatches),
        .pending           (pending)
    );

    always #5 clk = ~clk;

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int idle_length();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (pop_stall > 0)
        begin
            pop <= 1'b0;
            pop_stall--;
        end
        else
        begin
            pop <= 1'b1;
            if (pop_calm > 0)
            begin
                pop_calm--;
            end
            else
            begin
                pop_stall = idle_length();
                if ($urandom_range(199) == 0)
                    pop_calm = $urandom_range(50, 150);
            end
        end
    end

    task automatic send_item(input logic op, input logic [63:0] hash);
        int gap;
        if (push_calm > 0)
        begin
            push_calm--;
            gap = 0;
        end
        else
        begin
            gap = idle_length();
            if ($urandom_range(99) == 0)
                push_calm = $urandom_range(30, 80);
        end
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        operation <= op;
        key_hash  <= hash;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [ABUND_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_MIN_ABUND || idx == REG_MAX_ABUND)
        begin
            @(negedge clk);
            while (!full)
                @(negedge clk);
            while (full)
                @(negedge clk);
        end
        @(posedge clk);
    endtask

    function automatic logic [INDEX_BITS-1:0] pool_slot(int k);
        logic [31:0] spread;
        if (k == 0)
            return '0;
        if (k == 1)
            return '1;
        spread = k * 32'h0000_2b3d;
        return spread[INDEX_BITS-1:0];
    endfunction

    function automatic logic [63:0] pick_hash(int pool);
        logic [63:0] h;
        h = {$urandom, $urandom};
        if ($urandom_range(4) != 0)
            h[INDEX_BITS-1:0] = pool_slot($urandom_range(pool - 1));
        return h;
    endfunction

    task automatic run_mix(input int n, input int pool, input int count_pct);
        logic op;
        repeat (n)
        begin
            op = ($urandom_range(99) < count_pct) ? OP_COUNT : OP_QUERY;
            send_item(op, pick_hash(pool));
        end
    endtask

    initial
    begin
        wait (rst_n);
        @(posedge clk);

        // Default thresholds: extremes of the hash and aliasing through the ignored high bits.
        send_item(OP_QUERY, 64'h0000_0000_0000_0000);
        send_item(OP_COUNT, 64'h0000_0000_0000_0000);
        send_item(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_COUNT, 64'hFFFF_FFFF_FFFF_0000);
        send_item(OP_QUERY, 64'h8000_0000_0000_0000);
        send_item(OP_COUNT, 64'h0000_0000_0001_0000);
        send_item(OP_COUNT, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(OP_QUERY, 64'h5555_5555_5555_5555);
        run_mix(380, 16, 70);
        drain_results();

        // A small saturation limit, so counters reach it and stall there.
        write_reg(REG_MAX_ABUND, 8'd3);
        write_reg(REG_MIN_ABUND, 8'd2);
        repeat (4) send_item(OP_COUNT, 64'h1234_5678_9ABC_0042);
        send_item(OP_QUERY, 64'h0000_0000_0000_0042);
        send_item(OP_COUNT, 64'hDEAD_BEEF_0000_0777);
        send_item(OP_QUERY, 64'h0000_0000_0000_0777);
        run_mix(300, 12, 70);
        drain_results();

        // Zero minimum and the widest limit; one key is driven to the counter's top.
        write_reg(REG_MIN_ABUND, 8'd0);
        write_reg(REG_MAX_ABUND, 8'd255);
        run_mix(400, 1, 85);
        drain_results();

        // Minimum above maximum, so one counter can sit in both totals.
        write_reg(REG_MIN_ABUND, 8'd255);
        write_reg(REG_MAX_ABUND, 8'd1);
        run_mix(250, 32, 70);
        drain_results();

        // A zero limit keeps every counter at zero.
        write_reg(REG_MAX_ABUND, 8'd0);
        run_mix(150, 8, 70);
        drain_results();

        // Writes beyond the register list leave thresholds and counters alone.
        write_reg(CFG_ADDR_W'(2), 8'hA5);
        write_reg(CFG_ADDR_W'(3), 8'h5A);
        write_reg(REG_MIN_ABUND, 8'd4);
        write_reg(REG_MAX_ABUND, 8'd40);
        run_mix(400, 6, 80);
        drain_results();

        repeat (20) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/scbf_pkg.sv
rtl/core/scbf_fifo.sv
rtl/core/scbf_back.sv
rtl/core/saturating_counting_bloom_filter.sv
dv/scbf_checker.sv
dv/saturating_counting_bloom_filter_tb.sv
